// ===== hdl/gpla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpla_pkg
// Shared types, constants and helpers for the genotype pair table accumulator.
// ----------------------------------------------------------------------------
package gpla_pkg;

  localparam int MAX_BYTES   = 1024;
  localparam int SLOTS       = 4;
  localparam int CODES       = 8;
  localparam int TABLE_DEPTH = 32 * MAX_BYTES;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int PIDX_W      = $clog2(MAX_BYTES);
  localparam int POS_W       = PIDX_W + 1;
  localparam int BANK_DEPTH  = TABLE_DEPTH / SLOTS;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int VALUE_W     = 32;
  localparam int TREE_W      = VALUE_W + 2;
  localparam int SUM_W       = 48;
  localparam int COUNT_W     = 13;
  localparam int MISS_W      = 3;

  localparam logic [POS_W-1:0]   POS_LIMIT = POS_W'(MAX_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ACCUM = 1'b1
  } op_t;

  localparam logic [1:0] GENO_MISSING = 2'd3;

  // control carried alongside the table read data
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              add_en;
    logic              ovr;
    logic [MISS_W-1:0] miss;
  } lk_ctrl_t;

  function automatic logic pair_missing(input logic [1:0] gi, input logic [1:0] gj);
    return (gi == GENO_MISSING) || (gj == GENO_MISSING);
  endfunction

  // 3-bit lookup code for one genotype pair; a missing pair maps to 7
  function automatic logic [2:0] pair_code(input logic [1:0] gi, input logic [1:0] gj);
    logic [1:0] o;
    logic [1:0] a;
    o = gi | gj;
    a = gi & gj;
    return {o[1], a[0] | a[1] | pair_missing(gi, gj), o[0]};
  endfunction

endpackage

// ===== hdl/gpla_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpla_if
// Valid/ready channels for load/accumulate items and for results.
// ----------------------------------------------------------------------------
interface gpla_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [gpla_pkg::ADDR_W-1:0]    table_address;
  logic signed [gpla_pkg::VALUE_W-1:0] table_value;
  logic [7:0]                     geno_byte_i;
  logic [7:0]                     geno_byte_j;
  logic                           last;

  modport source (output valid, op, table_address, table_value, geno_byte_i,
                  geno_byte_j, last, input ready);
  modport sink   (input valid, op, table_address, table_value, geno_byte_i,
                  geno_byte_j, last, output ready);
endinterface

interface gpla_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gpla_pkg::SUM_W-1:0]  pair_sum;
  logic [gpla_pkg::COUNT_W-1:0]       missing_count;
  logic                               overrun;

  modport source (output valid, pair_sum, missing_count, overrun, input ready);
  modport sink   (input valid, pair_sum, missing_count, overrun, output ready);
endinterface

// ===== hdl/genotype_pair_lut_accumulate_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// genotype_pair_lut_accumulate_top
// Genotype pair product table lookup and accumulation for one sample pair.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries load transactions (op 0: one table entry written) and
//   accumulate transactions (op 1: one packed byte of four genotypes from
//   each sample). out_ch carries one result per accumulate transaction
//   that has last set: the saturated sum, the missing pair count and the
//   overrun flag, after which the running state clears.
//   The table sits in four RAM banks, one per genotype slot, so all four
//   lookups of a byte pair are done in the same cycle. One transaction is
//   taken per clock while in_ch ready is high. A result passes from its
//   last transaction through the table read, the adder tree and the
//   accumulate into the output register, each registered in turn.
//   A load followed at once by an accumulate sees the new entry: writes and
//   reads both happen at the accept edge, in order.
//   Reset clears position, sums, flags and pipeline valids; the table keeps
//   no reset and must be loaded before use. While out_ch stalls, non-last
//   transactions keep flowing; a last transaction waits in the pipeline
//   and in_ch ready drops once the pipeline is full.
// ----------------------------------------------------------------------------
module genotype_pair_lut_accumulate_top (
  input  logic       clk,
  input  logic       rst,
  gpla_in_if.sink    in_ch,
  gpla_out_if.source out_ch
);

  gpla_pkg::lk_ctrl_t                  s1;
  logic signed [gpla_pkg::VALUE_W-1:0] rdata [gpla_pkg::SLOTS];
  logic                                s1_move;

  gpla_lookup u_lookup (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .op            (in_ch.op),
    .table_address (in_ch.table_address),
    .table_value   (in_ch.table_value),
    .geno_byte_i   (in_ch.geno_byte_i),
    .geno_byte_j   (in_ch.geno_byte_j),
    .last          (in_ch.last),
    .s1_move       (s1_move),
    .s1            (s1),
    .rdata         (rdata)
  );

  gpla_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .s1            (s1),
    .rdata         (rdata),
    .s1_move       (s1_move),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .pair_sum      (out_ch.pair_sum),
    .missing_count (out_ch.missing_count),
    .overrun       (out_ch.overrun)
  );

endmodule

// ===== hdl/gpla_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpla_lookup
// Byte position tracking, code formation and four banked product table RAMs.
// ----------------------------------------------------------------------------
module gpla_lookup (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   op,
  input  logic [gpla_pkg::ADDR_W-1:0]            table_address,
  input  logic signed [gpla_pkg::VALUE_W-1:0]    table_value,
  input  logic [7:0]                             geno_byte_i,
  input  logic [7:0]                             geno_byte_j,
  input  logic                                   last,
  input  logic                                   s1_move,
  output gpla_pkg::lk_ctrl_t                     s1,
  output logic signed [gpla_pkg::VALUE_W-1:0]    rdata [gpla_pkg::SLOTS]
);

  logic [gpla_pkg::POS_W-1:0]     pos;
  logic [gpla_pkg::POS_W-1:0]     pos_next;
  gpla_pkg::lk_ctrl_t             s1_next;
  logic                           accept;
  logic                           is_accum;
  logic                           ovr;
  logic [2:0]                     code [gpla_pkg::SLOTS];
  logic [gpla_pkg::SLOTS-1:0]     miss_bits;
  logic [gpla_pkg::MISS_W-1:0]    miss_sum;
  logic [gpla_pkg::BANK_AW-1:0]   waddr;
  logic [1:0]                     wbank;

  assign in_ready = !s1.valid || s1_move;
  assign accept   = in_valid && in_ready;
  assign is_accum = (op == gpla_pkg::OP_ACCUM);
  assign ovr      = (pos >= gpla_pkg::POS_LIMIT);

  // table address = {position, slot, code}; slot picks the bank
  assign wbank = table_address[4:3];
  assign waddr = {table_address[gpla_pkg::ADDR_W-1:5], table_address[2:0]};

  always_comb begin
    miss_sum = '0;
    for (int s = 0; s < gpla_pkg::SLOTS; s++) begin
      code[s]      = gpla_pkg::pair_code(geno_byte_i[2*s +: 2], geno_byte_j[2*s +: 2]);
      miss_bits[s] = gpla_pkg::pair_missing(geno_byte_i[2*s +: 2], geno_byte_j[2*s +: 2]);
      miss_sum     = miss_sum + gpla_pkg::MISS_W'(miss_bits[s]);
    end
  end

  always_comb begin
    pos_next       = pos;
    s1_next        = s1;
    s1_next.valid  = s1.valid && !s1_move;
    if (accept) begin
      s1_next.valid  = is_accum;
      s1_next.last   = last;
      s1_next.add_en = !ovr;
      s1_next.ovr    = ovr;
      s1_next.miss   = ovr ? '0 : miss_sum;
      if (is_accum) begin
        if (last) begin
          pos_next = '0;
        end else if (!ovr) begin
          pos_next = pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1.valid <= 1'b0;
      s1.last  <= 1'b0;
      s1.add_en <= 1'b0;
      s1.ovr   <= 1'b0;
      s1.miss  <= '0;
    end else begin
      pos <= pos_next;
      s1  <= s1_next;
    end
  end

  for (genvar b = 0; b < gpla_pkg::SLOTS; b++) begin : g_bank
    logic [gpla_pkg::VALUE_W-1:0] mem [gpla_pkg::BANK_DEPTH];
    logic [gpla_pkg::BANK_AW-1:0] raddr;
    logic                         we;
    logic                         re;

    assign raddr = {pos[gpla_pkg::PIDX_W-1:0], code[b]};
    assign we    = accept && !is_accum && (wbank == 2'(b));
    assign re    = accept && is_accum;

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= table_value;
      end
      if (re) begin
        rdata[b] <= mem[raddr];
      end
    end
  end

endmodule

// ===== hdl/gpla_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpla_accum
// Adds the four table entries, accumulates with saturation, holds the result.
// ----------------------------------------------------------------------------
module gpla_accum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gpla_pkg::lk_ctrl_t                    s1,
  input  logic signed [gpla_pkg::VALUE_W-1:0]   rdata [gpla_pkg::SLOTS],
  output logic                                  s1_move,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gpla_pkg::SUM_W-1:0]     pair_sum,
  output logic [gpla_pkg::COUNT_W-1:0]          missing_count,
  output logic                                  overrun
);

  gpla_pkg::lk_ctrl_t                   s2;
  logic signed [gpla_pkg::TREE_W-1:0]   tree;
  logic signed [gpla_pkg::TREE_W-1:0]   tree_next;
  logic [gpla_pkg::SUM_W-1:0]           acc;
  logic [gpla_pkg::SUM_W-1:0]           acc_next;
  logic [gpla_pkg::COUNT_W-1:0]         miss_acc;
  logic [gpla_pkg::COUNT_W-1:0]         miss_acc_next;
  logic                                 ovr_flag;
  logic                                 ovr_flag_next;
  logic [gpla_pkg::SUM_W:0]             sum_wide;
  logic [gpla_pkg::COUNT_W:0]           cnt_wide;
  logic                                 out_free;
  logic                                 s2_take;
  logic                                 s2_can;
  logic                                 emit;

  assign out_free = !out_valid || out_ready;
  assign s2_take  = s2.valid && (!s2.last || out_free);
  assign s2_can   = !s2.valid || s2_take;
  assign s1_move  = s1.valid && s2_can;
  assign emit     = s2_take && s2.last;

  always_comb begin
    tree_next = gpla_pkg::TREE_W'(rdata[0]) + gpla_pkg::TREE_W'(rdata[1])
              + gpla_pkg::TREE_W'(rdata[2]) + gpla_pkg::TREE_W'(rdata[3]);
    if (!s1.add_en) begin
      tree_next = '0;
    end
  end

  // saturating accumulate; overflow shows as the two top bits differing
  always_comb begin
    sum_wide = {acc[gpla_pkg::SUM_W-1], acc}
             + {{(gpla_pkg::SUM_W + 1 - gpla_pkg::TREE_W){tree[gpla_pkg::TREE_W-1]}}, tree};
    cnt_wide = {1'b0, miss_acc} + (gpla_pkg::COUNT_W + 1)'(s2.miss);
    if (sum_wide[gpla_pkg::SUM_W] != sum_wide[gpla_pkg::SUM_W-1]) begin
      acc_next = sum_wide[gpla_pkg::SUM_W] ? gpla_pkg::SUM_MIN : gpla_pkg::SUM_MAX;
    end else begin
      acc_next = sum_wide[gpla_pkg::SUM_W-1:0];
    end
    if (cnt_wide[gpla_pkg::COUNT_W]) begin
      miss_acc_next = gpla_pkg::COUNT_MAX;
    end else begin
      miss_acc_next = cnt_wide[gpla_pkg::COUNT_W-1:0];
    end
    ovr_flag_next = ovr_flag | s2.ovr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid  <= 1'b0;
      s2.last   <= 1'b0;
      s2.add_en <= 1'b0;
      s2.ovr    <= 1'b0;
      s2.miss   <= '0;
      acc       <= '0;
      miss_acc  <= '0;
      ovr_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_can) begin
        s2 <= s1;
      end
      if (s2_take) begin
        if (s2.last) begin
          acc      <= '0;
          miss_acc <= '0;
          ovr_flag <= 1'b0;
        end else begin
          acc      <= acc_next;
          miss_acc <= miss_acc_next;
          ovr_flag <= ovr_flag_next;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      tree <= tree_next;
    end
    if (emit) begin
      pair_sum      <= acc_next;
      missing_count <= miss_acc_next;
      overrun       <= ovr_flag_next;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the genotype pair table accumulator against a cycle-free predictor.
// Product table entries are loaded on demand so that no accumulate ever reads
// an entry that was not written. Directed tests cover code mapping, value
// extremes, table overwrite and overrun. A back-pressure test stalls the
// result side long enough to fill the block. Random sample pairs follow.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     RANDOM_ITEMS   = 450;
  localparam int     DRAIN_CYCLES   = 20;
  localparam longint SUM_HI         = (longint'(1) <<< (gpla_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_LO         = -(longint'(1) <<< (gpla_pkg::SUM_W - 1));

  typedef struct {
    gpla_pkg::op_t                       op;
    logic [gpla_pkg::ADDR_W-1:0]         table_address;
    logic signed [gpla_pkg::VALUE_W-1:0] table_value;
    logic [7:0]                          geno_byte_i;
    logic [7:0]                          geno_byte_j;
    logic                                last;
  } geno_item_t;

  typedef struct {
    logic signed [gpla_pkg::SUM_W-1:0] pair_sum;
    logic [gpla_pkg::COUNT_W-1:0]      missing_count;
    logic                              overrun;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst;

  gpla_in_if  in_ch ();
  gpla_out_if out_ch ();

  genotype_pair_lut_accumulate_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [gpla_pkg::VALUE_W-1:0] model_lut [gpla_pkg::TABLE_DEPTH];
  bit                                  lut_loaded [gpla_pkg::TABLE_DEPTH];
  int unsigned                         byte_pos;
  logic signed [gpla_pkg::SUM_W-1:0]   run_sum;
  int unsigned                         run_missing;
  bit                                  run_overrun;
  pair_result_t                        pending_pair_results [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int idle_pct       = 0;
  bit hold_request   = 1'b0;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned lut_index(int unsigned pos, int s, logic [7:0] bi,
                                            logic [7:0] bj);
    logic [1:0] a;
    logic [1:0] b;
    logic [2:0] code;
    logic       miss;
    a = bi[2*s +: 2];
    b = bj[2*s +: 2];
    miss = (a == gpla_pkg::GENO_MISSING) || (b == gpla_pkg::GENO_MISSING);
    code[0] = a[0] | b[0];
    code[1] = (a[0] & b[0]) | (a[1] & b[1]) | miss;
    code[2] = a[1] | b[1];
    return 32 * pos + 8 * s + code;
  endfunction

  function automatic void update_pair_model(geno_item_t it);
    longint       add;
    longint       total;
    logic [1:0]   a;
    logic [1:0]   b;
    pair_result_t res;
    if (it.op == gpla_pkg::OP_LOAD) begin
      model_lut[it.table_address]  = it.table_value;
      lut_loaded[it.table_address] = 1'b1;
      return;
    end
    if (byte_pos >= gpla_pkg::MAX_BYTES) begin
      run_overrun = 1'b1;
    end else begin
      add = 0;
      for (int s = 0; s < gpla_pkg::SLOTS; s++) begin
        a = it.geno_byte_i[2*s +: 2];
        b = it.geno_byte_j[2*s +: 2];
        add += model_lut[lut_index(byte_pos, s, it.geno_byte_i, it.geno_byte_j)];
        if (a == gpla_pkg::GENO_MISSING || b == gpla_pkg::GENO_MISSING) run_missing++;
      end
      total = longint'(run_sum) + add;
      if (total > SUM_HI) total = SUM_HI;
      if (total < SUM_LO) total = SUM_LO;
      run_sum = total[gpla_pkg::SUM_W-1:0];
      if (run_missing > 32'(gpla_pkg::COUNT_MAX)) run_missing = 32'(gpla_pkg::COUNT_MAX);
      byte_pos++;
    end
    if (it.last) begin
      res.pair_sum      = run_sum;
      res.missing_count = run_missing[gpla_pkg::COUNT_W-1:0];
      res.overrun       = run_overrun;
      pending_pair_results.push_back(res);
      byte_pos    = 0;
      run_sum     = '0;
      run_missing = 0;
      run_overrun = 1'b0;
    end
  endfunction

  // Starts and ends just after a rising edge; valid stays high on return so
  // back-to-back transactions need no second assignment in one step.
  task automatic offer_item(geno_item_t it);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= it.op;
    in_ch.table_address <= it.table_address;
    in_ch.table_value   <= it.table_value;
    in_ch.geno_byte_i   <= it.geno_byte_i;
    in_ch.geno_byte_j   <= it.geno_byte_j;
    in_ch.last          <= it.last;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    update_pair_model(it);
  endtask

  function automatic logic signed [gpla_pkg::VALUE_W-1:0] random_entry();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(gpla_pkg::VALUE_W-1){1'b1}}};
      1:       return {1'b1, {(gpla_pkg::VALUE_W-1){1'b0}}};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_load(logic [gpla_pkg::ADDR_W-1:0] addr,
                           logic signed [gpla_pkg::VALUE_W-1:0] value, logic last);
    geno_item_t it;
    it.op            = gpla_pkg::OP_LOAD;
    it.table_address = addr;
    it.table_value   = value;
    it.geno_byte_i   = 8'($urandom);
    it.geno_byte_j   = 8'($urandom);
    it.last          = last;
    offer_item(it);
  endtask

  // loads any entry this byte pair will read that was never written
  task automatic send_accum(logic [7:0] bi, logic [7:0] bj, logic last);
    geno_item_t  it;
    int unsigned idx;
    if (byte_pos < gpla_pkg::MAX_BYTES) begin
      for (int s = 0; s < gpla_pkg::SLOTS; s++) begin
        idx = lut_index(byte_pos, s, bi, bj);
        if (!lut_loaded[idx])
          send_load(idx[gpla_pkg::ADDR_W-1:0], random_entry(), 1'($urandom_range(0, 1)));
      end
    end
    it.op            = gpla_pkg::OP_ACCUM;
    it.table_address = gpla_pkg::ADDR_W'($urandom);
    it.table_value   = $urandom;
    it.geno_byte_i   = bi;
    it.geno_byte_j   = bj;
    it.last          = last;
    offer_item(it);
  endtask

  task automatic send_random_pair(int len);
    logic [7:0] bi;
    logic [7:0] bj;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_load(gpla_pkg::ADDR_W'($urandom), random_entry(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
        bi = 8'hFF;
        bj = 8'($urandom);
      end else begin
        bi = 8'($urandom);
        bj = 8'($urandom);
      end
      send_accum(bi, bj, k == len - 1);
    end
  endtask

  task automatic test_codes_and_extremes();
    idle_pct = 0;
    send_load('0, {1'b0, {(gpla_pkg::VALUE_W-1){1'b1}}}, 1'b1);
    send_load('1, {1'b1, {(gpla_pkg::VALUE_W-1){1'b0}}}, 1'b1);
    send_load(gpla_pkg::ADDR_W'(1), {1'b1, {(gpla_pkg::VALUE_W-1){1'b0}}}, 1'b0);
    // every genotype pair once over four byte pairs, one first genotype per slot
    send_accum(8'hE4, 8'h00, 1'b0);
    send_accum(8'hE4, 8'h55, 1'b0);
    send_accum(8'hE4, 8'hAA, 1'b0);
    send_accum(8'hE4, 8'hFF, 1'b1);
    // overwrite an entry, then read it back
    send_load('0, 32'sh1234_5678, 1'b0);
    send_load('0, -32'sh0001_0000, 1'b0);
    send_accum(8'h00, 8'h00, 1'b1);
    // all missing at extremes of the value range
    for (int s = 0; s < gpla_pkg::SLOTS; s++)
      send_load(gpla_pkg::ADDR_W'(8 * s + 7), {1'b0, {(gpla_pkg::VALUE_W-1){1'b1}}}, 1'b0);
    send_accum(8'hFF, 8'hFF, 1'b1);
    for (int s = 0; s < gpla_pkg::SLOTS; s++)
      send_load(gpla_pkg::ADDR_W'(8 * s + 7), {1'b1, {(gpla_pkg::VALUE_W-1){1'b0}}}, 1'b0);
    send_accum(8'hFF, 8'h3C, 1'b1);
  endtask

  task automatic test_overrun();
    idle_pct = 10;
    for (int k = 0; k < gpla_pkg::MAX_BYTES; k++) send_accum(8'hFF, 8'hFF, 1'b0);
    send_accum(8'($urandom), 8'($urandom), 1'b0);
    send_accum(8'($urandom), 8'($urandom), 1'b1);
    // state must be clear afterwards
    send_random_pair(2);
    send_accum(8'($urandom), 8'($urandom), 1'b1);
  endtask

  task automatic test_backpressure();
    idle_pct     = 0;
    hold_request = 1'b1;
    for (int k = 0; k < 8; k++) send_random_pair($urandom_range(1, 8));
  endtask

  task automatic test_random_pairs();
    int stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      if ($urandom_range(0, 6) == 0) send_random_pair($urandom_range(7, 40));
      else send_random_pair($urandom_range(1, 6));
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end else begin
          out_ch.ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  always @(negedge clk) begin : result_check
    pair_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_pair_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result sum=%0d missing=%0d overrun=%0b", $realtime,
                   out_ch.pair_sum, out_ch.missing_count, out_ch.overrun);
      end else begin
        want = pending_pair_results.pop_front();
        if (out_ch.pair_sum !== want.pair_sum || out_ch.missing_count !== want.missing_count
            || out_ch.overrun !== want.overrun) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch sum exp %0d got %0d, missing exp %0d got %0d,",
                      " overrun exp %0b got %0b"},
                     $realtime, want.pair_sum, out_ch.pair_sum, want.missing_count,
                     out_ch.missing_count, want.overrun, out_ch.overrun);
        end
      end
    end
  end

  always @(negedge clk) begin : watchdog
    int quiet_cycles;
    if (rst === 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.op            = gpla_pkg::OP_LOAD;
    in_ch.table_address = '0;
    in_ch.table_value   = '0;
    in_ch.geno_byte_i   = '0;
    in_ch.geno_byte_j   = '0;
    in_ch.last          = 1'b0;
    byte_pos            = 0;
    run_sum             = '0;
    run_missing         = 0;
    run_overrun         = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_codes_and_extremes();
    test_overrun();
    test_backpressure();
    test_random_pairs();

    in_ch.valid <= 1'b0;
    while (pending_pair_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gpla_pkg.sv
hdl/gpla_if.sv
hdl/gpla_lookup.sv
hdl/gpla_accum.sv
hdl/genotype_pair_lut_accumulate_top.sv
tb/sv/testbench.sv
